/* design/odo_pkg.sv */
// Shared constants, types and helper functions for the planar odometry core.
// Used by every module in this folder; depends on nothing else.

package odo_pkg;

    localparam int POSITION_BITS   = 32;
    localparam int SPEED_BITS      = 16;
    localparam int TRIG_STEPS      = 16;

    localparam int ANGLE_TABLE_LEN = 24;
    localparam int TRIG_ITER       = (TRIG_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : TRIG_STEPS;
    localparam int ITER_W          = $clog2(TRIG_ITER);

    localparam int ANGLE_W         = 32;
    localparam int VEC_SHIFT       = 14;
    localparam int XW              = SPEED_BITS + VEC_SHIFT + 2;

    localparam int GAIN_W          = 16;
    localparam int DT_W            = 16;
    localparam int DT_CNT_W        = $clog2(DT_W);
    localparam int GD_W            = GAIN_W + DT_W;
    localparam int MUL_DIGITS      = GD_W / 2;
    localparam int MUL_CNT_W       = $clog2(MUL_DIGITS);
    localparam int ACC_W           = XW + 3;
    localparam int OUT_SHIFT       = 38;
    localparam int MUL_SHIFT       = OUT_SHIFT - GD_W;

    localparam int SUM_W = ((POSITION_BITS > ACC_W) ? POSITION_BITS : ACC_W) + 1;
    localparam int OUT_W = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    localparam int IN_DATA_W       = 64;
    localparam int OUT_DATA_W      = 112;

    localparam logic [GAIN_W-1:0]  CORDIC_GAIN  = 16'd39797;
    localparam logic [ANGLE_W-1:0] EIGHTH_TURN  = 32'h2000_0000;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    localparam logic [ANGLE_W-1:0] ANGLE_TABLE [ANGLE_TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    localparam logic signed [SUM_W-1:0] POS_MAX =
        {{(SUM_W - POSITION_BITS + 1){1'b0}}, {(POSITION_BITS - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;
    localparam logic signed [OUT_W-1:0] OUT_MAX = {{(OUT_W - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = ~OUT_MAX;

    typedef logic signed [SPEED_BITS-1:0]    speed_t;
    typedef logic signed [XW-1:0]            vec_t;
    typedef logic signed [ACC_W-1:0]         acc_t;
    typedef logic signed [POSITION_BITS-1:0] pos_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_MUL,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [GD_W-1:0]    gain_time;
        logic [ANGLE_W-1:0] heading_step;
    } scale_res_t;

    // Keep the low SPEED_BITS of the sign-extended command.
    function automatic speed_t speed_from_cmd(input logic [15:0] v);
        logic signed [31:0] w;
        w = 32'(signed'(v));
        return w[SPEED_BITS-1:0];
    endfunction

    function automatic logic [15:0] speed_echo(input speed_t s);
        logic signed [31:0] w;
        w = 32'(s);
        return w[15:0];
    endfunction

    function automatic pos_t pos_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] c;
        if (s > POS_MAX)
            c = POS_MAX;
        else if (s < POS_MIN)
            c = POS_MIN;
        else
            c = s;
        return c[POSITION_BITS-1:0];
    endfunction

    function automatic logic [31:0] out_sat(input pos_t p);
        logic signed [OUT_W-1:0] w;
        w = OUT_W'(p);
        if (w > OUT_MAX)
            w = OUT_MAX;
        else if (w < OUT_MIN)
            w = OUT_MIN;
        return w[31:0];
    endfunction

endpackage

/* design/odo_cordic.sv */
// Iterative CORDIC rotation: exact quarter-turn pre-rotation, then one
// micro-rotation per cycle on a shared add/shift unit. Depends on odo_pkg.

module odo_cordic
    import odo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  vec_t               x_in,
    input  vec_t               y_in,
    input  logic [ANGLE_W-1:0] angle,
    output logic               busy,
    output vec_t               x_out,
    output vec_t               y_out
);

    localparam logic [1:0] QUAD_ZERO  = 2'd0;
    localparam logic [1:0] QUAD_ONE   = 2'd1;
    localparam logic [1:0] QUAD_TWO   = 2'd2;
    localparam logic [1:0] QUAD_THREE = 2'd3;

    logic                      busy_reg, busy_next;
    logic [ITER_W-1:0]         iter_reg, iter_next;
    vec_t                      x_reg, x_next;
    vec_t                      y_reg, y_next;
    logic signed [ANGLE_W-1:0] z_reg, z_next;

    logic [ANGLE_W-1:0] biased;
    logic [1:0]         quad;
    logic [ANGLE_W-1:0] resid;
    vec_t               x_pre, y_pre;
    vec_t               xs, ys;

    always_comb begin
        biased = angle + EIGHTH_TURN;
        quad   = biased[ANGLE_W-1:ANGLE_W-2];
        resid  = angle - {quad, {(ANGLE_W - 2){1'b0}}};
        case (quad)
            QUAD_ZERO:
            begin
                x_pre = x_in;
                y_pre = y_in;
            end
            QUAD_ONE:
            begin
                x_pre = -y_in;
                y_pre = x_in;
            end
            QUAD_TWO:
            begin
                x_pre = -x_in;
                y_pre = -y_in;
            end
            QUAD_THREE:
            begin
                x_pre = y_in;
                y_pre = -x_in;
            end
            default:
            begin
                x_pre = x_in;
                y_pre = y_in;
            end
        endcase
    end

    always_comb begin
        xs        = x_reg >>> iter_reg;
        ys        = y_reg >>> iter_reg;
        busy_next = busy_reg;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            x_next    = x_pre;
            y_next    = y_pre;
            z_next    = signed'(resid);
        end else if (busy_reg) begin
            // rotate toward zero residual angle
            if (!z_reg[ANGLE_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - signed'(ANGLE_TABLE[iter_reg]);
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + signed'(ANGLE_TABLE[iter_reg]);
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(TRIG_ITER - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy  = busy_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

/* design/odo_tick_scale.sv */
// Bit-serial scaling by the elapsed time: forms gain * dt and turn * dt,
// one bit of dt per cycle, LSB first. Depends on odo_pkg.

module odo_tick_scale
    import odo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DT_W-1:0]   elapsed,
    input  logic [15:0]       turn,
    output logic              busy,
    output scale_res_t        res
);

    logic                busy_reg, busy_next;
    logic [DT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DT_W-1:0]     dt_sh_reg, dt_sh_next;
    logic [GD_W-1:0]     gain_sh_reg, gain_sh_next;
    logic [ANGLE_W-1:0]  turn_sh_reg, turn_sh_next;
    logic [GD_W-1:0]     gd_reg, gd_next;
    logic [ANGLE_W-1:0]  hstep_reg, hstep_next;

    always_comb begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        dt_sh_next   = dt_sh_reg;
        gain_sh_next = gain_sh_reg;
        turn_sh_next = turn_sh_reg;
        gd_next      = gd_reg;
        hstep_next   = hstep_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            dt_sh_next   = elapsed;
            gain_sh_next = GD_W'(CORDIC_GAIN);
            turn_sh_next = ANGLE_W'(signed'(turn));
            gd_next      = '0;
            hstep_next   = '0;
        end else if (busy_reg) begin
            if (dt_sh_reg[0]) begin
                gd_next    = gd_reg + gain_sh_reg;
                hstep_next = hstep_reg + turn_sh_reg;
            end
            dt_sh_next   = dt_sh_reg >> 1;
            gain_sh_next = gain_sh_reg << 1;
            turn_sh_next = turn_sh_reg << 1;
            cnt_next     = cnt_reg + 1'b1;
            if (cnt_reg == DT_CNT_W'(DT_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        dt_sh_reg   <= dt_sh_next;
        gain_sh_reg <= gain_sh_next;
        turn_sh_reg <= turn_sh_next;
        gd_reg      <= gd_next;
        hstep_reg   <= hstep_next;
    end

    assign busy             = busy_reg;
    assign res.gain_time    = gd_reg;
    assign res.heading_step = hstep_reg;

endmodule

/* design/odo_serial_mul.sv */
// Radix-4 serial multiplier: signed a times unsigned b, two bits of b per
// cycle, giving floor(a * b / 2^GD_W). Depends on odo_pkg.

module odo_serial_mul
    import odo_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  vec_t            a,
    input  logic [GD_W-1:0] b,
    output logic            busy,
    output acc_t            prod
);

    logic                 busy_reg, busy_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    acc_t                 a_reg, a_next;
    logic [GD_W-1:0]      b_sh_reg, b_sh_next;
    acc_t                 acc_reg, acc_next;

    acc_t addend;
    acc_t sum;

    always_comb begin
        addend    = (b_sh_reg[0] ? a_reg : '0) + (b_sh_reg[1] ? (a_reg <<< 1) : '0);
        sum       = acc_reg + addend;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_sh_next = b_sh_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = ACC_W'(a);
            b_sh_next = b;
            acc_next  = '0;
        end else if (busy_reg) begin
            // drop the two settled low bits; the arithmetic shift floors
            acc_next  = sum >>> 2;
            b_sh_next = b_sh_reg >> 2;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_DIGITS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        a_reg    <= a_next;
        b_sh_reg <= b_sh_next;
        acc_reg  <= acc_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

/* design/planar_dead_reckoning_odometry_core.sv */
// Top level of the planar odometry core: stream ports, pose state, control.
// Depends on odo_pkg, odo_cordic, odo_tick_scale and odo_serial_mul.
//
//   channel  dir  signals                    payload
//   s_       in   tvalid tready tdata tuser  tuser: kind; tdata: speeds, turn, dt
//   m_       out  tvalid tready tdata        tdata: x, y, heading, speed, turn
//
// A command is latched as it is taken and the core stays idle. A tick runs the CORDIC
// rotation beside the bit-serial dt scaling, then the radix-4 serial multipliers, then
// updates the pose and loads the output register in the write state; the next item can
// be taken in the cycle after that write. A new item is taken while a result still waits
// in the output register; a tick that finishes against a full register holds. Reset
// clears the pose, the latched command and the control state.

module planar_dead_reckoning_odometry_core
    import odo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] cmd_forward_speed, [31:16] cmd_lateral_speed,
    // [47:32] cmd_turn_rate, [63:48] elapsed_time
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] kind
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] position_x, [63:32] position_y, [79:64] heading_angle,
    // [95:80] speed_echo, [111:96] turn_rate_echo
    output logic [OUT_DATA_W-1:0] m_tdata
);

    state_t state_reg, state_next;

    speed_t             fwd_reg;
    speed_t             lat_reg;
    logic [15:0]        turn_reg;
    pos_t               pos_x_reg;
    pos_t               pos_y_reg;
    logic [ANGLE_W-1:0] heading_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic s_accept;
    logic tick_start;
    logic mul_start;
    logic write_en;

    logic       cordic_busy;
    logic       scale_busy;
    logic       mul_x_busy;
    logic       mul_y_busy;
    vec_t       rot_x, rot_y;
    vec_t       vec_x, vec_y;
    scale_res_t scale_res;
    acc_t       prod_x, prod_y;

    acc_t                    dx, dy;
    pos_t                    pos_x_next, pos_y_next;
    logic [ANGLE_W-1:0]      heading_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign tick_start = s_accept && (s_tuser == KIND_TICK);

    assign vec_x = XW'(fwd_reg) <<< VEC_SHIFT;
    assign vec_y = XW'(lat_reg) <<< VEC_SHIFT;

    odo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tick_start),
        .x_in  (vec_x),
        .y_in  (vec_y),
        .angle (heading_reg),
        .busy  (cordic_busy),
        .x_out (rot_x),
        .y_out (rot_y)
    );

    odo_tick_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (tick_start),
        .elapsed (s_tdata[63:48]),
        .turn    (turn_reg),
        .busy    (scale_busy),
        .res     (scale_res)
    );

    odo_serial_mul u_mul_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (rot_x),
        .b     (scale_res.gain_time),
        .busy  (mul_x_busy),
        .prod  (prod_x)
    );

    odo_serial_mul u_mul_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (rot_y),
        .b     (scale_res.gain_time),
        .busy  (mul_y_busy),
        .prod  (prod_y)
    );

    always_comb begin
        dx           = prod_x >>> MUL_SHIFT;
        dy           = prod_y >>> MUL_SHIFT;
        pos_x_next   = pos_sat(SUM_W'(pos_x_reg) + SUM_W'(dx));
        pos_y_next   = pos_sat(SUM_W'(pos_y_reg) + SUM_W'(dy));
        heading_next = heading_reg + {scale_res.heading_step[ANGLE_W-5:0], 4'b0000};
    end

    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        write_en   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_start)
                    state_next = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                if (!cordic_busy && !scale_busy) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (!mul_x_busy && !mul_y_busy)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    write_en   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (write_en)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            fwd_reg      <= '0;
            lat_reg      <= '0;
            turn_reg     <= '0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            heading_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept && (s_tuser == KIND_COMMAND)) begin
                fwd_reg  <= speed_from_cmd(s_tdata[15:0]);
                lat_reg  <= speed_from_cmd(s_tdata[31:16]);
                turn_reg <= s_tdata[47:32];
            end
            if (write_en) begin
                pos_x_reg   <= pos_x_next;
                pos_y_reg   <= pos_y_next;
                heading_reg <= heading_next;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (write_en)
            m_tdata_reg <= {turn_reg,
                            speed_echo(fwd_reg),
                            heading_next[ANGLE_W-1:ANGLE_W-16],
                            out_sat(pos_y_next),
                            out_sat(pos_x_next)};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !cordic_busy && !scale_busy && !mul_x_busy && !mul_y_busy)
        else $error("arithmetic unit busy while idle");

    a_command_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tuser == KIND_COMMAND) |=>
            $stable(pos_x_reg) && $stable(pos_y_reg) && state_reg == ST_IDLE)
        else $error("command transaction moved the pose");

    a_heading_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !write_en |=> $stable(heading_reg))
        else $error("heading changed without a result");

    a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        write_en |=> m_tvalid)
        else $error("result not presented after pose update");
`endif

endmodule

/* bench/tb_planar_dead_reckoning_odometry_core.sv */
// Self-checking bench for planar_dead_reckoning_odometry_core: directed, saturation and random
// command/tick streams with random idling on both stream sides, checked against a pose tracker.
// Depends on odo_pkg and the core only.

module tb_planar_dead_reckoning_odometry_core;
    import odo_pkg::*;

    localparam int     TRACK_LEN   = 24;
    localparam int     ROT_PRESCALE = 14;
    localparam longint GAIN_Q16    = 39797;
    localparam int     POSE_SHIFT  = 38;
    localparam int     ITEM_TARGET = 900;
    localparam int     SPRINT_TICKS = 280;
    localparam int     STALL_LIMIT = 4000;
    localparam int     SETTLE_CYCLES = 100;

    typedef struct {
        logic        kind;
        logic [15:0] fwd;
        logic [15:0] lat;
        logic [15:0] turn;
        logic [15:0] dt;
        int unsigned gap;
        bit          drain_first;
    } odo_item_t;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic [15:0] turn_echo;
        logic [15:0] fwd_echo;
        logic [15:0] heading;
        logic [31:0] y;
        logic [31:0] x;
    } pose_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    odo_item_t    pending_items[$];
    pose_report_t expected_poses[$];
    odo_item_t    active_item;
    int unsigned  send_gap_left = 0;

    // pose tracker state
    longint      trk_fwd = 0;
    longint      trk_lat = 0;
    longint      trk_turn = 0;
    longint      trk_x = 0;
    longint      trk_y = 0;
    logic [31:0] trk_heading = '0;

    // stimulus planning
    bit          quiet_run = 0;
    bit          drain_next = 0;
    logic [15:0] plan_turn = '0;
    logic [31:0] plan_heading = '0;

    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned recv_stall_left = 0;
    int unsigned holdoff_left = 0;
    int unsigned idle_cycles = 0;

    logic [31:0] atan_turns [TRACK_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    planar_dead_reckoning_odometry_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint narrow_speed(input logic [15:0] v);
        longint w;
        w = longint'(signed'(v));
        return (w <<< (64 - SPEED_BITS)) >>> (64 - SPEED_BITS);
    endfunction

    // Rotate (vx, vy) counterclockwise: exact quarter turns, then CORDIC on the residual.
    task automatic rotate_by_heading(inout longint vx, inout longint vy, input logic [31:0] h);
        logic [31:0] quad;
        logic [31:0] resid;
        longint      z;
        longint      t;
        longint      xs;
        longint      ys;
        int          steps;
        int          i;
        quad  = ((h + 32'h2000_0000) >> 30) & 32'd3;
        resid = h - (quad << 30);
        z     = longint'(signed'(resid));
        case (quad)
            32'd1:
            begin
                t  = vx;
                vx = -vy;
                vy = t;
            end
            32'd2:
            begin
                vx = -vx;
                vy = -vy;
            end
            32'd3:
            begin
                t  = vx;
                vx = vy;
                vy = -t;
            end
            default: ;
        endcase
        steps = (TRIG_STEPS > TRACK_LEN) ? TRACK_LEN : TRIG_STEPS;
        for (i = 0; i < steps; i++)
        begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (z >= 0)
            begin
                vx = vx - ys;
                vy = vy + xs;
                z  = z - longint'(atan_turns[i]);
            end
            else
            begin
                vx = vx + ys;
                vy = vy - xs;
                z  = z + longint'(atan_turns[i]);
            end
        end
    endtask

    // Advance the tracked pose by one accepted transaction; a tick queues its report.
    task automatic track_item(input odo_item_t it);
        longint       vx;
        longint       vy;
        longint       turn_delta;
        pose_report_t rep;
        if (it.kind == KIND_COMMAND)
        begin
            trk_fwd  = narrow_speed(it.fwd);
            trk_lat  = narrow_speed(it.lat);
            trk_turn = longint'(signed'(it.turn));
        end
        else
        begin
            vx = trk_fwd <<< ROT_PRESCALE;
            vy = trk_lat <<< ROT_PRESCALE;
            rotate_by_heading(vx, vy, trk_heading);
            trk_x = clamp_bits(trk_x + ((vx * GAIN_Q16 * longint'(it.dt)) >>> POSE_SHIFT),
                               POSITION_BITS);
            trk_y = clamp_bits(trk_y + ((vy * GAIN_Q16 * longint'(it.dt)) >>> POSE_SHIFT),
                               POSITION_BITS);
            turn_delta  = trk_turn * longint'(it.dt) * 16;
            trk_heading = trk_heading + turn_delta[31:0];
            rep.x         = 32'(clamp_bits(trk_x, 32));
            rep.y         = 32'(clamp_bits(trk_y, 32));
            rep.heading   = trk_heading[31:16];
            rep.fwd_echo  = trk_fwd[15:0];
            rep.turn_echo = trk_turn[15:0];
            expected_poses.push_back(rep);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic queue_item(input logic kind, input logic [15:0] fwd, input logic [15:0] lat,
                              input logic [15:0] turn, input logic [15:0] dt);
        odo_item_t it;
        it.kind        = kind;
        it.fwd         = fwd;
        it.lat         = lat;
        it.turn        = turn;
        it.dt          = dt;
        it.gap         = quiet_run ? 0 : $urandom_range(0, 3);
        it.drain_first = drain_next;
        drain_next     = 0;
        pending_items.push_back(it);
    endtask

    // unused fields carry random content
    task automatic add_command(input logic [15:0] fwd, input logic [15:0] lat,
                               input logic [15:0] turn);
        plan_turn = turn;
        queue_item(KIND_COMMAND, fwd, lat, turn, 16'($urandom));
    endtask

    task automatic add_tick(input logic [15:0] dt);
        longint turn_delta;
        turn_delta   = longint'(signed'(plan_turn)) * longint'(dt) * 16;
        plan_heading = plan_heading + turn_delta[31:0];
        queue_item(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), dt);
    endtask

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            1, 2: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Sender: offer the next pending item once its gap has passed.
    always @(posedge clk)
    begin : drive_inputs
        odo_item_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                track_item(active_item);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap_left > 0)
                begin
                    send_gap_left <= send_gap_left - 1;
                    s_tvalid      <= 1'b0;
                end
                else if (pending_items.size() > 0 &&
                         (!pending_items[0].drain_first || expected_poses.size() == 0))
                begin
                    nxt = pending_items.pop_front();
                    active_item   <= nxt;
                    s_tvalid      <= 1'b1;
                    s_tdata       <= {nxt.dt, nxt.turn, nxt.lat, nxt.fwd};
                    s_tuser       <= nxt.kind;
                    send_gap_left <= nxt.gap;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result transaction, then stall at random or hold off long.
    always @(posedge clk)
    begin : watch_outputs
        pose_report_t got;
        pose_report_t want;
        logic         next_ready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_poses.size() == 0)
                begin
                    report_mismatch("unexpected result, x", got.x, 32'h0);
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if (got.x !== want.x)
                        report_mismatch("position_x", got.x, want.x);
                    if (got.y !== want.y)
                        report_mismatch("position_y", got.y, want.y);
                    if (got.heading !== want.heading)
                        report_mismatch("heading_angle", 32'(got.heading), 32'(want.heading));
                    if (got.fwd_echo !== want.fwd_echo)
                        report_mismatch("speed_echo", 32'(got.fwd_echo), 32'(want.fwd_echo));
                    if (got.turn_echo !== want.turn_echo)
                        report_mismatch("turn_rate_echo", 32'(got.turn_echo),
                                        32'(want.turn_echo));
                end
                results_seen++;
                if (results_seen == 60 || results_seen == 500)
                    holdoff_left = 250;
                else if (((results_seen / 50) % 4) == 3)
                    recv_stall_left = 0;
                else
                    recv_stall_left = $urandom_range(0, 3);
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                next_ready = 1'b0;
            end
            else if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
            end
            m_tready <= next_ready;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned next_drain_at;
        int unsigned n;
        int unsigned rate;
        int unsigned dt_part;
        int unsigned k;
        int unsigned count;

        // ticks straight out of reset, with nothing latched
        add_tick(16'h0000);
        add_tick(16'hFFFF);
        // extreme speeds and turn rates
        add_command(16'h7FFF, 16'h8000, 16'h7FFF);
        add_tick(16'hFFFF);
        add_tick(16'h0000);
        add_tick(16'h0001);
        add_command(16'h8000, 16'h7FFF, 16'h8000);
        add_tick(16'hFFFF);
        add_tick(16'h8000);
        // walk the heading through every quadrant at about a quarter turn per tick
        add_command(16'h0100, 16'h0080, 16'd1024);
        for (k = 0; k < 6; k++)
            add_tick(16'hFFFF);
        add_command(16'hFFFF, 16'h0001, 16'hFFFF);
        add_tick(16'hFFFF);
        add_tick(16'h0001);
        add_command(16'h0000, 16'h0000, 16'h0000);
        add_tick(16'h1234);

        // Bring the heading back to about zero without moving, then sprint into saturation.
        n = (~plan_heading + 32'd1) >> 4;
        rate    = n / 65535 + 1;
        dt_part = n / rate;
        drain_next = 1;
        add_command(16'h0000, 16'h0000, 16'(rate));
        add_tick(16'(dt_part));
        add_command(16'h0000, 16'h0000, 16'h0001);
        add_tick(16'(n - rate * dt_part));
        add_command(16'h7FFF, 16'h8000, 16'h0000);
        for (k = 0; k < SPRINT_TICKS; k++)
            add_tick(16'hFFFF);

        next_drain_at = pending_items.size() + 150;
        drain_next = 1;
        while (pending_items.size() < ITEM_TARGET)
        begin
            quiet_run = ($urandom_range(0, 3) == 0);
            if (pending_items.size() >= next_drain_at)
            begin
                drain_next = 1;
                next_drain_at += 150;
            end
            case ($urandom_range(0, 9))
                7:
                begin
                    count = $urandom_range(2, 4);
                    for (k = 0; k < count; k++)
                        add_command(16'($urandom), 16'($urandom), 16'($urandom));
                end
                8:
                begin
                    count = $urandom_range(1, 6);
                    for (k = 0; k < count; k++)
                        add_tick(pick_dt());
                end
                default:
                begin
                    add_command(pick_speed(), pick_speed(), pick_speed());
                    count = $urandom_range(1, 8);
                    for (k = 0; k < count; k++)
                        add_tick(pick_dt());
                end
            endcase
        end

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || s_tvalid || expected_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_poses.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
